FILE: sv/tskf_pkg.sv
// Package for the two-state Kalman filter: transfer payload types,
// register indexes, sequencer states and micro-operation codes.
// No dependencies.
package tskf_pkg;

   localparam int DataWidthDefault = 32;
   localparam int FracBitsDefault  = 16;
   localparam int NumRegs          = 7;
   localparam int AddrWidth        = 6;
   localparam logic [63:0] MeasNoiseReset = 64'd65536;

   typedef enum logic [2:0] {
      REG_TRANS_ROW0      = 3'd0,
      REG_TRANS_ROW1      = 3'd1,
      REG_OBSERVE_ROW     = 3'd2,
      REG_PROC_NOISE_ROW0 = 3'd3,
      REG_PROC_NOISE_ROW1 = 3'd4,
      REG_MEAS_NOISE      = 3'd5,
      REG_START_COV_DIAG  = 3'd6,
      REG_NONE            = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [31:0] measurement;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] estimate0;
      logic signed [31:0] estimate1;
      logic               singular_flag;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV_INIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_XM0, OP_XM1,
      OP_AP00, OP_AP01, OP_AP10, OP_AP11,
      OP_PM00, OP_PM01, OP_PM10, OP_PM11,
      OP_HP0, OP_HP1, OP_PH0, OP_PH1,
      OP_S, OP_HX, OP_Y,
      OP_X0, OP_X1,
      OP_T00, OP_T01, OP_T10, OP_T11,
      OP_P00, OP_P01, OP_P10, OP_P11
   } op_type;

endpackage

FILE: sv/two_state_kalman_filter.sv
// Each step runs 27 multiply-accumulate operations, most of them two-term, on one
// shared 32x32 multiplier, plus two 64-step radix-2 gain divisions; the divisions
// are skipped when S is zero.
// No new request is taken until the response has transferred and the block is idle.
// Reset: synchronous; clears state estimate and covariance, registers to defaults.
// Top level of the two-state Kalman filter; depends on tskf_pkg.
module two_state_kalman_filter #(
   parameter int DATA_WIDTH = tskf_pkg::DataWidthDefault,
   parameter int FRAC_BITS  = tskf_pkg::FracBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tskf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tskf_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tskf_pkg::AddrWidth-1:0] paddr,
   input  logic [63:0]                    pwdata,
   output logic [63:0]                    prdata,
   output logic                           pready
);

   localparam int EffW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
   localparam int EffF = (FRAC_BITS > 30) ? 30 : ((FRAC_BITS < 1) ? 1 : FRAC_BITS);
   localparam logic signed [63:0] SatHi = (64'sd1 <<< (EffW - 1)) - 64'sd1;
   localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;
   localparam logic signed [63:0] Half  = 64'sd1 <<< (EffF - 1);
   localparam logic signed [31:0] One   = 32'sd1 <<< EffF;

   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > SatHi) r = SatHi;
      if (v < SatLo) r = SatLo;
      return r[31:0];
   endfunction

   function automatic logic signed [31:0] word(input logic [31:0] w);
      return sat64(64'(signed'(w)));
   endfunction

   // configuration registers
   logic [63:0] cfg_ff [tskf_pkg::NumRegs];
   tskf_pkg::reg_idx_type csr_idx;
   logic csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = tskf_pkg::reg_idx_type'(paddr[5:3]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tskf_pkg::NumRegs; i++)
            cfg_ff[i] <= (i == int'(tskf_pkg::REG_MEAS_NOISE)) ? tskf_pkg::MeasNoiseReset
                                                                : 64'd0;
      end else if (csr_wr && csr_idx != tskf_pkg::REG_NONE) begin
         if (csr_idx == tskf_pkg::REG_MEAS_NOISE) begin
            cfg_ff[csr_idx] <= {33'd0, pwdata[30:0]};
         end else begin
            cfg_ff[csr_idx] <= pwdata;
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_idx != tskf_pkg::REG_NONE) prdata = cfg_ff[csr_idx];
   end

   logic signed [31:0] a00, a01, a10, a11, h0, h1, q00, q01, q10, q11, rn, pd0, pd1, id_w;
   assign a00  = word(cfg_ff[tskf_pkg::REG_TRANS_ROW0][31:0]);
   assign a01  = word(cfg_ff[tskf_pkg::REG_TRANS_ROW0][63:32]);
   assign a10  = word(cfg_ff[tskf_pkg::REG_TRANS_ROW1][31:0]);
   assign a11  = word(cfg_ff[tskf_pkg::REG_TRANS_ROW1][63:32]);
   assign h0   = word(cfg_ff[tskf_pkg::REG_OBSERVE_ROW][31:0]);
   assign h1   = word(cfg_ff[tskf_pkg::REG_OBSERVE_ROW][63:32]);
   assign q00  = word(cfg_ff[tskf_pkg::REG_PROC_NOISE_ROW0][31:0]);
   assign q01  = word(cfg_ff[tskf_pkg::REG_PROC_NOISE_ROW0][63:32]);
   assign q10  = word(cfg_ff[tskf_pkg::REG_PROC_NOISE_ROW1][31:0]);
   assign q11  = word(cfg_ff[tskf_pkg::REG_PROC_NOISE_ROW1][63:32]);
   assign rn   = sat64({33'd0, cfg_ff[tskf_pkg::REG_MEAS_NOISE][30:0]});
   assign pd0  = word(cfg_ff[tskf_pkg::REG_START_COV_DIAG][31:0]);
   assign pd1  = word(cfg_ff[tskf_pkg::REG_START_COV_DIAG][63:32]);
   assign id_w = sat64(64'(One));

   // filter state and intermediates
   logic signed [31:0] x0_ff, x1_ff, p00_ff, p01_ff, p10_ff, p11_ff, z_ff;
   logic signed [31:0] xm0_ff, xm1_ff, ap00_ff, ap01_ff, ap10_ff, ap11_ff;
   logic signed [31:0] pm00_ff, pm01_ff, pm10_ff, pm11_ff, hp0_ff, hp1_ff;
   logic signed [31:0] ph0_ff, ph1_ff, s_ff, hx_ff, y_ff, k0_ff, k1_ff;
   logic signed [31:0] t00_ff, t01_ff, t10_ff, t11_ff;
   logic               flag_ff;

   tskf_pkg::state_type state_ff, state_in;
   tskf_pkg::op_type    op_ff;
   logic [2:0]          phase_ff;
   logic                div_idx_ff;
   logic [5:0]          div_cnt_ff;
   logic [63:0]         div_num_ff;
   logic [32:0]         div_rem_ff;
   logic [31:0]         div_den_ff;
   logic                div_neg_ff;

   logic req_fire, rsp_fire, op_last, op_pre_div, div_last, s_zero;
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign op_last    = (phase_ff == 3'd4) && (op_ff == tskf_pkg::OP_P11);
   assign op_pre_div = (phase_ff == 3'd4) && (op_ff == tskf_pkg::OP_Y);
   assign div_last   = (div_cnt_ff == 6'd63);
   assign s_zero     = (s_ff == 32'sd0);

   // operand selection
   logic signed [31:0] opa0, opb0, opa1, opb1, addend;
   logic               neg;
   always_comb begin
      opa0 = '0; opb0 = '0; opa1 = '0; opb1 = '0; addend = '0; neg = 1'b0;
      unique case (op_ff)
         tskf_pkg::OP_XM0:  begin opa0 = a00; opb0 = x0_ff; opa1 = a01; opb1 = x1_ff; end
         tskf_pkg::OP_XM1:  begin opa0 = a10; opb0 = x0_ff; opa1 = a11; opb1 = x1_ff; end
         tskf_pkg::OP_AP00: begin opa0 = a00; opb0 = p00_ff; opa1 = a01; opb1 = p10_ff; end
         tskf_pkg::OP_AP01: begin opa0 = a00; opb0 = p01_ff; opa1 = a01; opb1 = p11_ff; end
         tskf_pkg::OP_AP10: begin opa0 = a10; opb0 = p00_ff; opa1 = a11; opb1 = p10_ff; end
         tskf_pkg::OP_AP11: begin opa0 = a10; opb0 = p01_ff; opa1 = a11; opb1 = p11_ff; end
         tskf_pkg::OP_PM00: begin
            opa0 = ap00_ff; opb0 = a00; opa1 = ap01_ff; opb1 = a01; addend = q00;
         end
         tskf_pkg::OP_PM01: begin
            opa0 = ap00_ff; opb0 = a10; opa1 = ap01_ff; opb1 = a11; addend = q01;
         end
         tskf_pkg::OP_PM10: begin
            opa0 = ap10_ff; opb0 = a00; opa1 = ap11_ff; opb1 = a01; addend = q10;
         end
         tskf_pkg::OP_PM11: begin
            opa0 = ap10_ff; opb0 = a10; opa1 = ap11_ff; opb1 = a11; addend = q11;
         end
         tskf_pkg::OP_HP0:  begin opa0 = h0; opb0 = pm00_ff; opa1 = h1; opb1 = pm10_ff; end
         tskf_pkg::OP_HP1:  begin opa0 = h0; opb0 = pm01_ff; opa1 = h1; opb1 = pm11_ff; end
         tskf_pkg::OP_PH0:  begin opa0 = pm00_ff; opb0 = h0; opa1 = pm01_ff; opb1 = h1; end
         tskf_pkg::OP_PH1:  begin opa0 = pm10_ff; opb0 = h0; opa1 = pm11_ff; opb1 = h1; end
         tskf_pkg::OP_S:    begin
            opa0 = hp0_ff; opb0 = h0; opa1 = hp1_ff; opb1 = h1; addend = rn;
         end
         tskf_pkg::OP_HX:   begin opa0 = h0; opb0 = xm0_ff; opa1 = h1; opb1 = xm1_ff; end
         tskf_pkg::OP_Y:    begin opa0 = hx_ff; opb0 = One; addend = z_ff; neg = 1'b1; end
         tskf_pkg::OP_X0:   begin opa0 = k0_ff; opb0 = y_ff; addend = xm0_ff; end
         tskf_pkg::OP_X1:   begin opa0 = k1_ff; opb0 = y_ff; addend = xm1_ff; end
         tskf_pkg::OP_T00:  begin opa0 = k0_ff; opb0 = h0; addend = id_w; neg = 1'b1; end
         tskf_pkg::OP_T01:  begin opa0 = k0_ff; opb0 = h1; neg = 1'b1; end
         tskf_pkg::OP_T10:  begin opa0 = k1_ff; opb0 = h0; neg = 1'b1; end
         tskf_pkg::OP_T11:  begin opa0 = k1_ff; opb0 = h1; addend = id_w; neg = 1'b1; end
         tskf_pkg::OP_P00:  begin opa0 = t00_ff; opb0 = pm00_ff; opa1 = t01_ff; opb1 = pm10_ff; end
         tskf_pkg::OP_P01:  begin opa0 = t00_ff; opb0 = pm01_ff; opa1 = t01_ff; opb1 = pm11_ff; end
         tskf_pkg::OP_P10:  begin opa0 = t10_ff; opb0 = pm00_ff; opa1 = t11_ff; opb1 = pm10_ff; end
         tskf_pkg::OP_P11:  begin opa0 = t10_ff; opb0 = pm01_ff; opa1 = t11_ff; opb1 = pm11_ff; end
         default: ;
      endcase
   end

   // shared multiplier, rounding stage and accumulator
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff, rnd_ff, acc_ff;
   logic signed [31:0] inner, mac_res;
   logic signed [63:0] term;
   assign mul_a   = (phase_ff == 3'd0) ? opa0 : opa1;
   assign mul_b   = (phase_ff == 3'd0) ? opb0 : opb1;
   assign inner   = sat64(acc_ff);
   assign term    = neg ? -64'(inner) : 64'(inner);
   assign mac_res = sat64(64'(addend) + term);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      rnd_ff  <= (prod_ff + Half) >>> EffF;
      if (phase_ff == 3'd2) acc_ff <= rnd_ff;
      if (phase_ff == 3'd3) acc_ff <= acc_ff + rnd_ff;
   end

   // serial divider
   logic signed [63:0] ph_sel, ph_mag;
   logic signed [32:0] s_mag;
   logic [32:0]        rem_sh, rem_n;
   logic               ge;
   logic [63:0]        num_n;
   logic signed [63:0] q_sat;
   logic signed [31:0] k_res;
   assign ph_sel = div_idx_ff ? 64'(ph1_ff) : 64'(ph0_ff);
   assign ph_mag = (ph_sel < 0) ? -ph_sel : ph_sel;
   assign s_mag  = (s_ff < 0) ? -33'(s_ff) : 33'(s_ff);
   assign rem_sh = {div_rem_ff[31:0], div_num_ff[63]};
   assign ge     = rem_sh >= {1'b0, div_den_ff};
   assign rem_n  = ge ? rem_sh - {1'b0, div_den_ff} : rem_sh;
   assign num_n  = {div_num_ff[62:0], ge};

   always_comb begin
      if (div_neg_ff) begin
         q_sat = (num_n > 64'(SatHi + 64'sd1)) ? SatLo : -signed'(num_n);
      end else begin
         q_sat = (num_n > 64'(SatHi)) ? SatHi : signed'(num_n);
      end
      k_res = q_sat[31:0];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tskf_pkg::ST_IDLE:     if (req_fire) state_in = tskf_pkg::ST_MAC;
         tskf_pkg::ST_MAC: begin
            if (op_pre_div) state_in = tskf_pkg::ST_DIV_INIT;
            else if (op_last) state_in = tskf_pkg::ST_DONE;
         end
         tskf_pkg::ST_DIV_INIT: state_in = s_zero ? tskf_pkg::ST_MAC : tskf_pkg::ST_DIV;
         tskf_pkg::ST_DIV: begin
            if (div_last) state_in = div_idx_ff ? tskf_pkg::ST_MAC : tskf_pkg::ST_DIV_INIT;
         end
         tskf_pkg::ST_DONE:     if (rsp_fire) state_in = tskf_pkg::ST_IDLE;
         default:               state_in = tskf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == tskf_pkg::ST_IDLE);
      rsp_valid = (state_ff == tskf_pkg::ST_DONE);
   end

   assign rsp_data.estimate0     = x0_ff;
   assign rsp_data.estimate1     = x1_ff;
   assign rsp_data.singular_flag = flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tskf_pkg::ST_IDLE;
         op_ff      <= tskf_pkg::OP_XM0;
         phase_ff   <= '0;
         div_idx_ff <= 1'b0;
         div_cnt_ff <= '0;
         flag_ff    <= 1'b0;
         x0_ff <= '0; x1_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            tskf_pkg::ST_IDLE: begin
               op_ff      <= tskf_pkg::OP_XM0;
               phase_ff   <= '0;
               div_idx_ff <= 1'b0;
               if (req_fire) begin
                  z_ff    <= word(req_data.measurement);
                  flag_ff <= 1'b0;
                  if (req_data.restart) begin
                     x0_ff <= '0; x1_ff <= '0;
                     p00_ff <= pd0; p01_ff <= '0; p10_ff <= '0; p11_ff <= pd1;
                  end
               end
            end
            tskf_pkg::ST_MAC: begin
               if (phase_ff == 3'd4) begin
                  phase_ff <= '0;
                  if (!op_last) op_ff <= tskf_pkg::op_type'(op_ff + 5'd1);
                  case (op_ff)
                     tskf_pkg::OP_XM0:  xm0_ff  <= mac_res;
                     tskf_pkg::OP_XM1:  xm1_ff  <= mac_res;
                     tskf_pkg::OP_AP00: ap00_ff <= mac_res;
                     tskf_pkg::OP_AP01: ap01_ff <= mac_res;
                     tskf_pkg::OP_AP10: ap10_ff <= mac_res;
                     tskf_pkg::OP_AP11: ap11_ff <= mac_res;
                     tskf_pkg::OP_PM00: pm00_ff <= mac_res;
                     tskf_pkg::OP_PM01: pm01_ff <= mac_res;
                     tskf_pkg::OP_PM10: pm10_ff <= mac_res;
                     tskf_pkg::OP_PM11: pm11_ff <= mac_res;
                     tskf_pkg::OP_HP0:  hp0_ff  <= mac_res;
                     tskf_pkg::OP_HP1:  hp1_ff  <= mac_res;
                     tskf_pkg::OP_PH0:  ph0_ff  <= mac_res;
                     tskf_pkg::OP_PH1:  ph1_ff  <= mac_res;
                     tskf_pkg::OP_S:    s_ff    <= mac_res;
                     tskf_pkg::OP_HX:   hx_ff   <= mac_res;
                     tskf_pkg::OP_Y:    y_ff    <= mac_res;
                     tskf_pkg::OP_X0:   x0_ff   <= mac_res;
                     tskf_pkg::OP_X1:   x1_ff   <= mac_res;
                     tskf_pkg::OP_T00:  t00_ff  <= mac_res;
                     tskf_pkg::OP_T01:  t01_ff  <= mac_res;
                     tskf_pkg::OP_T10:  t10_ff  <= mac_res;
                     tskf_pkg::OP_T11:  t11_ff  <= mac_res;
                     tskf_pkg::OP_P00:  p00_ff  <= mac_res;
                     tskf_pkg::OP_P01:  p01_ff  <= mac_res;
                     tskf_pkg::OP_P10:  p10_ff  <= mac_res;
                     tskf_pkg::OP_P11:  p11_ff  <= mac_res;
                     default: ;
                  endcase
               end else begin
                  phase_ff <= phase_ff + 3'd1;
               end
            end
            tskf_pkg::ST_DIV_INIT: begin
               if (s_zero) begin
                  flag_ff <= 1'b1;
                  k0_ff   <= '0;
                  k1_ff   <= '0;
               end
               div_num_ff <= 64'(ph_mag) << EffF;
               div_rem_ff <= '0;
               div_den_ff <= s_mag[31:0];
               div_neg_ff <= (ph_sel < 0) ^ (s_ff < 0);
               div_cnt_ff <= '0;
            end
            tskf_pkg::ST_DIV: begin
               div_num_ff <= num_n;
               div_rem_ff <= rem_n;
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_last) begin
                  if (div_idx_ff) k1_ff <= k_res;
                  else k0_ff <= k_res;
                  div_idx_ff <= 1'b1;
               end
            end
            tskf_pkg::ST_DONE: ;
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_ready_valid_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready and response valid together");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= 3'd4) else $error("phase counter out of range");
   a_flag_gain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && flag_ff) |-> (k0_ff == 32'sd0 && k1_ff == 32'sd0))
      else $error("singular step with non-zero gain");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(x0_ff) && $stable(x1_ff)))
      else $error("response dropped before transfer");
`endif

endmodule
